// ----- design/bcc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Byte class counter package
// Shared types and constants: scanner states, mark kinds, the queued operation
// and the queue status passed between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package bcc_pkg;

   localparam int OUT_WIDTH      = 40;
   localparam int RSP_DATA_WIDTH = 208;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [7:0] BYTE_NUL = 8'h00;
   localparam logic [7:0] BYTE_TAB = 8'h09;
   localparam logic [7:0] BYTE_LF  = 8'h0a;
   localparam logic [7:0] BYTE_CR  = 8'h0d;
   localparam logic [7:0] BYTE_EF  = 8'hef;
   localparam logic [7:0] BYTE_BB  = 8'hbb;
   localparam logic [7:0] BYTE_BF  = 8'hbf;
   localparam logic [7:0] BYTE_FE  = 8'hfe;
   localparam logic [7:0] BYTE_FF  = 8'hff;

   typedef enum logic [2:0] {
      SC_PLAIN = 3'd0,
      SC_CR    = 3'd1,
      SC_START = 3'd2,
      SC_EF    = 3'd3,
      SC_FE    = 3'd4,
      SC_FF    = 3'd5,
      SC_EFBB  = 3'd6
   } scan_type;

   typedef enum logic [1:0] {
      MARK_NONE    = 2'd0,
      MARK_UTF8    = 2'd1,
      MARK_UTF16LE = 2'd2,
      MARK_UTF16BE = 2'd3
   } mark_type;

   // One classified item as the back end needs it.
   typedef struct packed {
      logic     clear;
      logic     inc_nul;
      logic     inc_tab;
      logic     inc_lf;
      logic     inc_crlf;
      logic     mark_set;
      mark_type mark_kind;
   } bcc_op_type;

   typedef struct packed {
      logic full;
      logic empty;
   } bcc_q_status_type;

endpackage
`default_nettype wire

// ----- design/bcc_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Byte class counter front end
// Accepts bytes, runs the byte order mark scanner and classifies each byte
// into an operation for the queue.
// ----------------------------------------------------------------------------
module bcc_front import bcc_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [7:0]       data_byte,
   input  wire logic             new_stream,
   input  wire logic             accept,
   output bcc_op_type            op
);

   scan_type scan_ff;
   scan_type scan_in;
   scan_type cur_state;
   scan_type next_state;

   // A new stream restarts the scan before this byte is looked at.
   assign cur_state = new_stream ? SC_START : scan_ff;

   always_comb begin
      next_state = SC_PLAIN;
      if (data_byte == BYTE_CR) begin
         next_state = SC_CR;
      end else begin
         case (cur_state)
            SC_START: begin
               if (data_byte == BYTE_EF) begin
                  next_state = SC_EF;
               end else if (data_byte == BYTE_FE) begin
                  next_state = SC_FE;
               end else if (data_byte == BYTE_FF) begin
                  next_state = SC_FF;
               end
            end
            SC_EF: begin
               if (data_byte == BYTE_BB) begin
                  next_state = SC_EFBB;
               end
            end
            default: next_state = SC_PLAIN;
         endcase
      end
   end

   always_comb begin
      op           = '0;
      op.clear     = new_stream;
      op.inc_nul   = (data_byte == BYTE_NUL);
      op.inc_tab   = (data_byte == BYTE_TAB);
      op.inc_lf    = (data_byte == BYTE_LF) && (cur_state != SC_CR);
      op.inc_crlf  = (data_byte == BYTE_LF) && (cur_state == SC_CR);
      op.mark_kind = MARK_NONE;
      case (cur_state)
         SC_FE: begin
            op.mark_set  = (data_byte == BYTE_FF);
            op.mark_kind = MARK_UTF16BE;
         end
         SC_FF: begin
            op.mark_set  = (data_byte == BYTE_FE);
            op.mark_kind = MARK_UTF16LE;
         end
         SC_EFBB: begin
            op.mark_set  = (data_byte == BYTE_BF);
            op.mark_kind = MARK_UTF8;
         end
         default: op.mark_set = 1'b0;
      endcase
   end

   assign scan_in = accept ? next_state : scan_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= SC_START;
      end else begin
         scan_ff <= scan_in;
      end
   end

endmodule
`default_nettype wire

// ----- design/bcc_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Byte class counter operation queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module bcc_queue import bcc_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  bcc_op_type      push_op,
   input  wire logic       pop,
   output bcc_op_type      pop_op,
   output bcc_q_status_type status
);

   localparam int PTR_WIDTH = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0] LAST_PTR = PTR_WIDTH'(QUEUE_DEPTH - 1);

   bcc_op_type entry_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0] level_ff, level_in;

   assign status.full  = (level_ff == CNT_WIDTH'(QUEUE_DEPTH));
   assign status.empty = (level_ff == '0);
   assign pop_op       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         level_in = level_ff + 1'b1;
      end else if (pop && !push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule
`default_nettype wire

// ----- design/bcc_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Byte class counter back end
// Applies queued operations to the saturating counters and the mark kind; the
// counters double as the result register.
// ----------------------------------------------------------------------------
module bcc_back import bcc_pkg::*; #(
   parameter int COUNT_WIDTH = 40
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  bcc_op_type                op,
   input  bcc_q_status_type          q_status,
   output logic                      pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [OUT_WIDTH-1:0]      total_out,
   output logic [OUT_WIDTH-1:0]      nul_out,
   output logic [OUT_WIDTH-1:0]      tab_out,
   output logic [OUT_WIDTH-1:0]      lf_out,
   output logic [OUT_WIDTH-1:0]      crlf_out,
   output mark_type                  mark_out
);

   logic [COUNT_WIDTH-1:0] total_ff, total_in;
   logic [COUNT_WIDTH-1:0] nul_ff, nul_in;
   logic [COUNT_WIDTH-1:0] tab_ff, tab_in;
   logic [COUNT_WIDTH-1:0] lf_ff, lf_in;
   logic [COUNT_WIDTH-1:0] crlf_ff, crlf_in;
   mark_type               mark_ff, mark_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] cnt,
                                                   input logic clr, input logic en);
      logic [COUNT_WIDTH-1:0] base;
      base = clr ? '0 : cnt;
      if (en && (base != {COUNT_WIDTH{1'b1}})) begin
         return base + 1'b1;
      end
      return base;
   endfunction

   function automatic logic [OUT_WIDTH-1:0] to_out(input logic [COUNT_WIDTH-1:0] cnt);
      logic [COUNT_WIDTH+OUT_WIDTH-1:0] ext;
      ext = {{OUT_WIDTH{1'b0}}, cnt};
      return ext[OUT_WIDTH-1:0];
   endfunction

   // Take the next item only when the result slot is free or being emptied.
   assign pop = !q_status.empty && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      total_in     = total_ff;
      nul_in       = nul_ff;
      tab_in       = tab_ff;
      lf_in        = lf_ff;
      crlf_in      = crlf_ff;
      mark_in      = mark_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (pop) begin
         total_in     = bump(total_ff, op.clear, 1'b1);
         nul_in       = bump(nul_ff, op.clear, op.inc_nul);
         tab_in       = bump(tab_ff, op.clear, op.inc_tab);
         lf_in        = bump(lf_ff, op.clear, op.inc_lf);
         crlf_in      = bump(crlf_ff, op.clear, op.inc_crlf);
         mark_in      = op.mark_set ? op.mark_kind : (op.clear ? MARK_NONE : mark_ff);
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         nul_ff       <= '0;
         tab_ff       <= '0;
         lf_ff        <= '0;
         crlf_ff      <= '0;
         mark_ff      <= MARK_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         total_ff     <= total_in;
         nul_ff       <= nul_in;
         tab_ff       <= tab_in;
         lf_ff        <= lf_in;
         crlf_ff      <= crlf_in;
         mark_ff      <= mark_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign total_out = to_out(total_ff);
   assign nul_out   = to_out(nul_ff);
   assign tab_out   = to_out(tab_ff);
   assign lf_out    = to_out(lf_ff);
   assign crlf_out  = to_out(crlf_ff);
   assign mark_out  = mark_ff;

endmodule
`default_nettype wire

// ----- design/byte_class_counter_bom_detect.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Byte class counter with byte order mark detection
// Path: an accepted item is written into the queue; the back end pops it and
//    applies it to the counters, which hold the shown result.
// Throughput: one item per cycle unless the result side stalls (queue fills).
// Reset: counters and mark kind clear, scanner waits for a stream start, the
//    queue empties and no result is shown; no clearing pass is needed.
// ----------------------------------------------------------------------------
module byte_class_counter_bom_detect import bcc_pkg::*; #(
   parameter int COUNT_WIDTH = 40
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // Input item: tdata[7:0] data_byte; tuser[0] new_stream.
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [7:0]                req_tdata,
   input  wire logic                      req_tuser,
   // Result item: tdata[39:0] total_count, [79:40] nul_count,
   // [119:80] tab_count, [159:120] lf_count, [199:160] crlf_count,
   // [201:200] bom_kind, [207:202] zero.
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0]      rsp_tdata
);

   // The front end classifies each byte and steps the mark scanner as the
   // item is accepted; the queue lets it carry on while the result side is
   // stalled, and the back end applies the operations to the counters.
   bcc_op_type       front_op;
   bcc_op_type       back_op;
   bcc_q_status_type q_status;
   logic             req_accept;
   logic             q_pop;
   logic [OUT_WIDTH-1:0] total_out, nul_out, tab_out, lf_out, crlf_out;
   mark_type         mark_out;

   assign req_tready = !q_status.full;
   assign req_accept = req_tvalid && req_tready;

   bcc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .data_byte  (req_tdata),
      .new_stream (req_tuser),
      .accept     (req_accept),
      .op         (front_op)
   );

   bcc_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (req_accept),
      .push_op (front_op),
      .pop     (q_pop),
      .pop_op  (back_op),
      .status  (q_status)
   );

   bcc_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .op        (back_op),
      .q_status  (q_status),
      .pop       (q_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .total_out (total_out),
      .nul_out   (nul_out),
      .tab_out   (tab_out),
      .lf_out    (lf_out),
      .crlf_out  (crlf_out),
      .mark_out  (mark_out)
   );

   // Pack the result fields from the lowest bit up, zero padded to bytes.
   assign rsp_tdata = {{(RSP_DATA_WIDTH - 5 * OUT_WIDTH - 2){1'b0}}, mark_out,
                       crlf_out, lf_out, tab_out, nul_out, total_out};

   // After reset the queue is empty and no stale result is shown.
   a_reset_clean: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("result or full queue left over after reset");

   // The queue can never report full and empty together.
   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue reports full and empty at once");

   // The back end only takes an item when the result slot is free or being emptied.
   a_pop_slot_free: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (!rsp_tvalid || rsp_tready))
      else $error("result overwritten before it was taken");

   // A pop never happens on an empty queue.
   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("pop from an empty queue");

endmodule
`default_nettype wire

// ----- test/byte_class_counter_bom_detect_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte class counter with byte order mark detection: testbench
// Streams bytes into the counter, predicts the running counts and the mark
// kind for every accepted item, and checks each result field by field. The
// stimulus covers every mark, broken marks, line endings during the mark
// scan and restarts in mid-stream. Both sides stall at random.
// ----------------------------------------------------------------------------
module byte_class_counter_bom_detect_tb;
   import bcc_pkg::*;

   // The counters are built at their full width, as the block is used.
   localparam int          CNT_BITS   = 40;
   localparam logic [63:0] CNT_MAX    = (64'd1 << CNT_BITS) - 64'd1;
   localparam int          CYCLE_CAP  = 3000000;
   localparam int          DRAIN_WAIT = 6;

   // One input item as it waits for the driver.
   typedef struct packed {
      logic [7:0] val;
      logic       fresh;
   } stream_item_type;

   // One set of counts as the block should show it.
   typedef struct packed {
      logic [OUT_WIDTH-1:0] total;
      logic [OUT_WIDTH-1:0] nul;
      logic [OUT_WIDTH-1:0] tab;
      logic [OUT_WIDTH-1:0] lf;
      logic [OUT_WIDTH-1:0] crlf;
      mark_type             mark;
   } byte_counts_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [7:0]                req_tdata = 8'h00;
   logic                      req_tuser = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;

   stream_item_type byte_queue[$];    // items not yet offered to the block
   byte_counts_type count_queue[$];   // predicted results not yet seen

   // Idle percentages for each side; the stimulus process moves them on.
   int send_idle_pct = 22;
   int recv_idle_pct = 73;

   int   errors = 0;
   int   cycles = 0;
   logic req_taken = 1'b0;

   // Predictor state, a private copy of what the block holds.
   logic [63:0] tally_total, tally_nul, tally_tab, tally_lf, tally_crlf;
   mark_type    found_mark;
   scan_type    scan_now;

   byte_class_counter_bom_detect #(.COUNT_WIDTH(CNT_BITS)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [7:0] data_byte
      .req_tuser  (req_tuser),   // [0] new_stream
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)    // [39:0] total, [79:40] nul, [119:80] tab,
                                 // [159:120] lf, [199:160] crlf,
                                 // [201:200] bom_kind, [207:202] zero
   );

   // 2 ns clock.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   function automatic logic [63:0] sat_inc(input logic [63:0] v);
      return (v < CNT_MAX) ? v + 64'd1 : v;
   endfunction

   task automatic clear_tallies();
      tally_total = '0;
      tally_nul   = '0;
      tally_tab   = '0;
      tally_lf    = '0;
      tally_crlf  = '0;
      found_mark  = MARK_NONE;
      scan_now    = SC_START;
   endtask

   // Counts one accepted byte and queues the result it should produce.
   task automatic count_byte(input logic [7:0] val, input logic fresh);
      scan_type        st;
      scan_type        nxt;
      byte_counts_type exp_counts;
      if (fresh) begin
         clear_tallies();
      end
      st = scan_now;

      tally_total = sat_inc(tally_total);
      if (val == BYTE_NUL) begin
         tally_nul = sat_inc(tally_nul);
      end else if (val == BYTE_TAB) begin
         tally_tab = sat_inc(tally_tab);
      end else if (val == BYTE_LF) begin
         // Only an LF straight after a CR makes a pair.
         if (st == SC_CR) begin
            tally_crlf = sat_inc(tally_crlf);
         end else begin
            tally_lf = sat_inc(tally_lf);
         end
      end

      // A CR always ends the mark scan; anything that does not continue a
      // mark ends it too, and the scan never starts again mid-stream.
      if (val == BYTE_CR) begin
         nxt = SC_CR;
      end else begin
         nxt = SC_PLAIN;
         case (st)
            SC_START: begin
               if (val == BYTE_EF) nxt = SC_EF;
               else if (val == BYTE_FE) nxt = SC_FE;
               else if (val == BYTE_FF) nxt = SC_FF;
            end
            SC_EF: begin
               if (val == BYTE_BB) nxt = SC_EFBB;
            end
            SC_FE: begin
               if (val == BYTE_FF) found_mark = MARK_UTF16BE;
            end
            SC_FF: begin
               if (val == BYTE_FE) found_mark = MARK_UTF16LE;
            end
            SC_EFBB: begin
               if (val == BYTE_BF) found_mark = MARK_UTF8;
            end
            default: begin
            end
         endcase
      end
      scan_now = nxt;

      exp_counts.total = tally_total[OUT_WIDTH-1:0];
      exp_counts.nul   = tally_nul[OUT_WIDTH-1:0];
      exp_counts.tab   = tally_tab[OUT_WIDTH-1:0];
      exp_counts.lf    = tally_lf[OUT_WIDTH-1:0];
      exp_counts.crlf  = tally_crlf[OUT_WIDTH-1:0];
      exp_counts.mark  = found_mark;
      count_queue.push_back(exp_counts);
   endtask

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------

   // Prints one line per failure and counts it.
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      errors++;
      $display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
   endtask

   task automatic check_counts(input logic [RSP_DATA_WIDTH-1:0] word);
      byte_counts_type want;
      if (count_queue.size() == 0) begin
         report_mismatch("result with nothing expected", word[63:0], 64'd0);
      end else begin
         want = count_queue.pop_front();
         if (word[39:0] !== want.total)
            report_mismatch("total_count", 64'(word[39:0]), 64'(want.total));
         if (word[79:40] !== want.nul)
            report_mismatch("nul_count", 64'(word[79:40]), 64'(want.nul));
         if (word[119:80] !== want.tab)
            report_mismatch("tab_count", 64'(word[119:80]), 64'(want.tab));
         if (word[159:120] !== want.lf)
            report_mismatch("lf_count", 64'(word[159:120]), 64'(want.lf));
         if (word[199:160] !== want.crlf)
            report_mismatch("crlf_count", 64'(word[199:160]), 64'(want.crlf));
         if (word[201:200] !== want.mark)
            report_mismatch("bom_kind", 64'(word[201:200]), 64'(want.mark));
         if (word[207:202] !== 6'd0)
            report_mismatch("padding", 64'(word[207:202]), 64'd0);
      end
   endtask

   // ------------------------------------------------------------------------
   // Monitor: samples both handshakes at the rising edge. An accepted input
   // item goes through the predictor at once, so the expectation is always
   // queued before its result can appear.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_taken = 1'b0;
         clear_tallies();
      end else begin
         req_taken = req_tvalid && req_tready;
         if (req_taken) begin
            count_byte(req_tdata, req_tuser);
         end
         if (rsp_tvalid && rsp_tready) begin
            check_counts(rsp_tdata);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Driver: works at the falling edge. An item that was offered but not
   // taken is held; otherwise the next one is offered, unless this cycle is
   // chosen as a gap. The receiver's ready is drawn afresh every cycle.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      stream_item_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (req_tvalid && !req_taken) begin
            // Still waiting for the block to take the current item.
         end else if (byte_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            item = byte_queue.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= item.val;
            req_tuser  <= item.fresh;
         end else begin
            req_tvalid <= 1'b0;
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Cycle counter guarding against a hang.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("byte_class_counter_bom_detect_tb: errors");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------

   task automatic push_item(input logic [7:0] val, input logic fresh);
      stream_item_type item;
      item.val   = val;
      item.fresh = fresh;
      byte_queue.push_back(item);
   endtask

   // Body bytes lean towards the classes that are counted and towards the
   // mark bytes, with plenty of fully random bytes so every bit toggles.
   function automatic logic [7:0] pick_body_byte();
      int sel;
      sel = $urandom_range(0, 11);
      case (sel)
         0:       return BYTE_NUL;
         1:       return BYTE_TAB;
         2, 3:    return BYTE_LF;
         4, 5:    return BYTE_CR;
         6: begin
            case ($urandom_range(0, 4))
               0:       return BYTE_EF;
               1:       return BYTE_BB;
               2:       return BYTE_BF;
               3:       return BYTE_FE;
               default: return BYTE_FF;
            endcase
         end
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Builds whole streams until at least n_items have been queued. Each
   // stream opens with a restart and, mostly, a full or partial mark; a few
   // stray restarts in the body break streams up.
   task automatic queue_streams(input int n_items);
      int start_size;
      int body_len;
      int head;
      start_size = byte_queue.size();
      while (byte_queue.size() - start_size < n_items) begin
         head = $urandom_range(0, 6);
         case (head)
            0: begin
               push_item(BYTE_EF, 1'b1);
               push_item(BYTE_BB, 1'b0);
               push_item(BYTE_BF, 1'b0);
            end
            1: begin
               push_item(BYTE_FF, 1'b1);
               push_item(BYTE_FE, 1'b0);
            end
            2: begin
               push_item(BYTE_FE, 1'b1);
               push_item(BYTE_FF, 1'b0);
            end
            3: begin
               push_item(BYTE_EF, 1'b1);
               push_item(BYTE_BB, 1'b0);
            end
            4: begin
               push_item(BYTE_EF, 1'b1);
            end
            5: begin
               push_item($urandom_range(0, 1) ? BYTE_FE : BYTE_FF, 1'b1);
            end
            default: begin
               push_item(pick_body_byte(), 1'b1);
            end
         endcase
         body_len = $urandom_range(0, 20);
         repeat (body_len) begin
            push_item(pick_body_byte(), ($urandom_range(0, 29) == 0));
         end
      end
   endtask

   // Waits until every queued item has been taken and every expected result
   // has arrived.
   task automatic wait_drained();
      while (byte_queue.size() != 0 || req_tvalid || count_queue.size() != 0) begin
         @(negedge clock);
      end
   endtask

   initial begin
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // Directed part. Full marks of all three kinds.
      push_item(BYTE_EF, 1'b1);
      push_item(BYTE_BB, 1'b0);
      push_item(BYTE_BF, 1'b0);
      push_item(BYTE_FF, 1'b1);
      push_item(BYTE_FE, 1'b0);
      push_item(BYTE_FE, 1'b1);
      push_item(BYTE_FF, 1'b0);
      // A CR in the middle of a mark ends the scan, and the LF after it
      // still pairs with the CR.
      push_item(BYTE_EF, 1'b1);
      push_item(BYTE_BB, 1'b0);
      push_item(BYTE_CR, 1'b0);
      push_item(BYTE_LF, 1'b0);
      // An LF during the scan is a bare LF.
      push_item(BYTE_FE, 1'b1);
      push_item(BYTE_LF, 1'b0);
      // Broken mark: a repeated FF is no mark.
      push_item(BYTE_FF, 1'b1);
      push_item(BYTE_FF, 1'b0);
      // CR CR LF gives one pair; TAB, then a full mark in mid-stream, which
      // must not be detected.
      push_item(BYTE_TAB, 1'b1);
      push_item(BYTE_CR, 1'b0);
      push_item(BYTE_CR, 1'b0);
      push_item(BYTE_LF, 1'b0);
      push_item(BYTE_NUL, 1'b0);
      push_item(BYTE_FF, 1'b0);
      push_item(BYTE_FE, 1'b0);
      // A byte between CR and LF breaks the pair.
      push_item(BYTE_LF, 1'b1);
      push_item(BYTE_CR, 1'b0);
      push_item(BYTE_TAB, 1'b0);
      push_item(BYTE_LF, 1'b0);

      // Random streams, first with a slow receiver.
      queue_streams(190);
      wait_drained();

      // Then a slow sender and a fast receiver.
      send_idle_pct = 73;
      recv_idle_pct = 22;
      queue_streams(190);
      wait_drained();

      // Finally no gaps at all, so items follow back to back.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_streams(120);
      wait_drained();

      // Give any stray result time to show up before the verdict.
      repeat (DRAIN_WAIT) @(negedge clock);
      if (errors == 0 && count_queue.size() == 0) begin
         $display("byte_class_counter_bom_detect_tb: clean");
      end else begin
         $display("byte_class_counter_bom_detect_tb: errors");
      end
      $finish;
   end

endmodule
